// ----- design/atau_pkg.sv -----
// Package for the accelerometer tilt unit: word types, CORDIC constants,
// arctangent table. No dependencies.
package atau_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STAGES   = 16;
  localparam int ACC_FRAC        = 24;
  localparam int ACC_W           = 32;
  localparam int SQ_W            = 32;
  localparam int RT_W            = 30;
  localparam int CX_W            = 36;
  localparam int SHIFT_OUT       = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int PIPE_LAT        = 1 + RT_W + CORDIC_STAGES + 1;
  localparam logic signed [ACC_W-1:0] NINETY_ACC = ACC_W'(90) <<< ACC_FRAC;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } accel_word_t;

  typedef struct packed {
    logic signed [15:0] tilt_about_x;
    logic signed [15:0] tilt_about_y;
  } tilt_word_t;

  function automatic logic signed [ACC_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd754974720;
      5'd1:  v = 32'sd445687602;
      5'd2:  v = 32'sd235489088;
      5'd3:  v = 32'sd119537938;
      5'd4:  v = 32'sd60000934;
      5'd5:  v = 32'sd30029717;
      5'd6:  v = 32'sd15018523;
      5'd7:  v = 32'sd7509720;
      5'd8:  v = 32'sd3754917;
      5'd9:  v = 32'sd1877466;
      5'd10: v = 32'sd938734;
      5'd11: v = 32'sd469367;
      5'd12: v = 32'sd234684;
      5'd13: v = 32'sd117342;
      5'd14: v = 32'sd58671;
      5'd15: v = 32'sd29335;
      5'd16: v = 32'sd14668;
      5'd17: v = 32'sd7334;
      5'd18: v = 32'sd3667;
      5'd19: v = 32'sd1833;
      5'd20: v = 32'sd917;
      5'd21: v = 32'sd458;
      5'd22: v = 32'sd229;
      5'd23: v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/atau_angle_pipe.sv -----
// One tilt angle lane: sum of squares, pipelined square root, pipelined
// CORDIC vectoring, clamp and round. Depends on atau_pkg.
module atau_angle_pipe import atau_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] num,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [15:0] angle
);

  // stage 0: squares
  logic [SQ_W-1:0] sq_r;
  logic [16:0]     mag0_r;
  logic            neg0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= SQ_W'(32'(a * a)) + SQ_W'(32'(b * b));
      mag0_r <= num[15] ? 17'(-18'(num)) : 17'(num);
      neg0_r <= num[15];
    end
  end

  // H = floor(sqrt(sq * 2^28)), one root bit per stage, 14 fraction bits
  logic [RT_W-1:0] h_r    [1:RT_W];
  logic [SQ_W-1:0] sqf_r  [1:RT_W];
  logic [16:0]     magf_r [1:RT_W];
  logic            negf_r [1:RT_W];
  logic            zf_r   [1:RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_root
    logic [RT_W-1:0]   h_in;
    logic [SQ_W-1:0]   sq_in;
    logic [16:0]       mag_in;
    logic              neg_in;
    logic              z_in;
    logic [RT_W-1:0]   cand;
    logic [2*RT_W-1:0] trial;
    if (k == 0) begin : g_src
      assign h_in   = '0;
      assign sq_in  = sq_r;
      assign mag_in = mag0_r;
      assign neg_in = neg0_r;
      assign z_in   = (sq_r == '0);
    end else begin : g_src
      assign h_in   = h_r[k];
      assign sq_in  = sqf_r[k];
      assign mag_in = magf_r[k];
      assign neg_in = negf_r[k];
      assign z_in   = zf_r[k];
    end
    always_comb begin
      cand  = h_in | RT_W'(1 << (RT_W - 1 - k));
      trial = (2*RT_W)'(cand) * (2*RT_W)'(cand);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        h_r[k+1]    <= (trial <= {sq_in, 28'd0}) ? cand : h_in;
        sqf_r[k+1]  <= sq_in;
        magf_r[k+1] <= mag_in;
        negf_r[k+1] <= neg_in;
        zf_r[k+1]   <= z_in;
      end
    end
  end

  // CORDIC vectoring
  logic signed [CX_W-1:0]  cx_r   [1:CORDIC_STAGES];
  logic signed [CX_W-1:0]  cy_r   [1:CORDIC_STAGES];
  logic signed [ACC_W-1:0] acc_r  [1:CORDIC_STAGES];
  logic                    negc_r [1:CORDIC_STAGES];
  logic                    zc_r   [1:CORDIC_STAGES];
  logic                    mz_r   [1:CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [CX_W-1:0]  x_in;
    logic signed [CX_W-1:0]  y_in;
    logic signed [ACC_W-1:0] a_in;
    logic                    n_in;
    logic                    z_in;
    logic                    m_in;
    if (i == 0) begin : g_src
      assign x_in = CX_W'(h_r[RT_W]);
      assign y_in = CX_W'({magf_r[RT_W], 14'd0});
      assign a_in = '0;
      assign n_in = negf_r[RT_W];
      assign z_in = zf_r[RT_W];
      assign m_in = (magf_r[RT_W] == '0);
    end else begin : g_src
      assign x_in = cx_r[i];
      assign y_in = cy_r[i];
      assign a_in = acc_r[i];
      assign n_in = negc_r[i];
      assign z_in = zc_r[i];
      assign m_in = mz_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_in[CX_W-1]) begin
          cx_r[i+1]  <= x_in + (y_in >>> i);
          cy_r[i+1]  <= y_in - (x_in >>> i);
          acc_r[i+1] <= a_in + atan_lut(5'(i));
        end else begin
          cx_r[i+1]  <= x_in - (y_in >>> i);
          cy_r[i+1]  <= y_in + (x_in >>> i);
          acc_r[i+1] <= a_in - atan_lut(5'(i));
        end
        negc_r[i+1] <= n_in;
        zc_r[i+1]   <= z_in;
        mz_r[i+1]   <= m_in;
      end
    end
  end

  // clamp, round, sign
  logic signed [ACC_W-1:0] accl;
  logic [ACC_W-1:0]        rnd;
  logic [15:0]             mag_out;
  logic signed [15:0]      angle_r;

  always_comb begin
    accl = acc_r[CORDIC_STAGES];
    if (zc_r[CORDIC_STAGES] || accl > NINETY_ACC) begin
      accl = NINETY_ACC;
    end else if (accl < 0) begin
      accl = '0;
    end
    rnd     = (ACC_W'(accl) + ACC_W'(1 << (SHIFT_OUT - 1))) >> SHIFT_OUT;
    mag_out = mz_r[CORDIC_STAGES] ? 16'd0 : rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= negc_r[CORDIC_STAGES] ? -mag_out : mag_out;
    end
  end

  assign angle = angle_r;

endmodule

// ----- design/accel_tilt_angles_unit.sv -----
// Accelerometer tilt unit top level: handshake and two angle lanes.
// Stages in order: squares, square root, CORDIC, round. One word per cycle
// unless stalled. The pipeline advances when the output is free or taken.
// Reset (rst_n, synchronous) clears only the valid bits; no state otherwise.
module accel_tilt_angles_unit import atau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  accel_word_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tilt_word_t  out_data
);

  logic [PIPE_LAT-1:0] vld_r;
  logic                en;
  logic signed [15:0]  ax, ay, ty_neg;

  assign en        = !vld_r[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  atau_angle_pipe u_tx (
    .clk(clk), .en(en), .num(in_data.accel_y),
    .a(in_data.accel_x), .b(in_data.accel_z), .angle(ax)
  );

  atau_angle_pipe u_ty (
    .clk(clk), .en(en), .num(in_data.accel_x),
    .a(in_data.accel_y), .b(in_data.accel_z), .angle(ay)
  );

  assign ty_neg = -ay;
  assign out_data.tilt_about_x = ax;
  assign out_data.tilt_about_y = ty_neg;

endmodule

// ----- bench/accel_tilt_angles_unit_tb.sv -----
// Testbench for accel_tilt_angles_unit: drives accelerometer words, predicts both
// tilt angles with an integer CORDIC model and compares every result word.
// Depends on atau_pkg and the design top level.
`timescale 1ns / 100ps

module accel_tilt_angles_unit_tb;
  import atau_pkg::*;

  localparam int WDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  accel_word_t in_data;
  logic        out_valid;
  logic        out_ready;
  tilt_word_t  out_data;

  tilt_word_t  tilt_q[$];
  int          err_cnt;
  int          idle_cnt;

  longint atan_deg[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  accel_tilt_angles_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_of(longint num, longint a, longint b);
    longint sq;
    longint mag;
    longint acc;
    longint xv;
    longint yv;
    longint dx;
    longint dy;
    longint rnd;
    sq  = a * a + b * b;
    mag = (num < 0) ? -num : num;
    if (mag == 0) return 0;
    if (sq == 0) begin
      acc = 64'sd90 <<< ACC_FRAC;
    end else begin
      xv  = root_floor(sq <<< 28);
      yv  = mag <<< 14;
      acc = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; acc += atan_deg[i];
        end else begin
          xv -= dx; yv += dy; acc -= atan_deg[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd90 <<< ACC_FRAC)) acc = 64'sd90 <<< ACC_FRAC;
    end
    rnd = (acc + (64'sd1 <<< (SHIFT_OUT - 1))) >>> SHIFT_OUT;
    return (num < 0) ? -rnd : rnd;
  endfunction

  function automatic tilt_word_t predict_tilt(accel_word_t w);
    tilt_word_t t;
    longint ax;
    longint ay;
    longint az;
    ax = w.accel_x;
    ay = w.accel_y;
    az = w.accel_z;
    t.tilt_about_x = 16'(tilt_of(ay, ax, az));
    t.tilt_about_y = 16'(-tilt_of(ax, ay, az));
    return t;
  endfunction

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    err_cnt++;
  endtask

  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    int gap;
    accel_word_t w;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.accel_x = x; w.accel_y = y; w.accel_z = z;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tilt_q.push_back(predict_tilt(w));
  endtask

  // result side: stall draw per word, check on every accepted word
  initial begin
    int stall;
    tilt_word_t exp_w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (tilt_q.size() == 0) begin
        report("unexpected word", int'(out_data), 0);
      end else begin
        exp_w = tilt_q.pop_front();
        if (out_data.tilt_about_x !== exp_w.tilt_about_x)
          report("tilt_about_x", out_data.tilt_about_x, exp_w.tilt_about_x);
        if (out_data.tilt_about_y !== exp_w.tilt_about_y)
          report("tilt_about_y", out_data.tilt_about_y, exp_w.tilt_about_y);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    logic signed [15:0] v[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
    send_word(0, 0, 0);
    send_word(0, 100, 0);
    send_word(0, -100, 0);
    send_word(100, 0, 0);
    send_word(-32768, 0, 0);
    send_word(0, 0, 32767);
    send_word(0, 0, -32768);
    send_word(-32768, -32768, -32768);
    send_word(32767, 32767, 32767);
    for (int i = 0; i < 15; i++)
      send_word(v[$urandom_range(0, 4)], v[$urandom_range(0, 4)], v[$urandom_range(0, 4)]);
  endtask

  task automatic test_random_full();
    for (int i = 0; i < 1000; i++)
      send_word(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random_small();
    int s;
    for (int i = 0; i < 625; i++) begin
      s = $urandom_range(0, 15);
      send_word(16'($signed(17'($urandom_range(0, 2 ** s)) - 17'(2 ** (s - 1)))),
                16'($signed(17'($urandom_range(0, 2 ** s)) - 17'(2 ** (s - 1)))),
                16'($urandom_range(0, 3) == 0 ? 0 : $urandom));
    end
  endtask

  initial begin
    int waited;
    err_cnt  = 0;
    idle_cnt = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_full();
    test_random_small();
    in_valid <= 1'b0;
    waited = 0;
    while (tilt_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_cnt == 0 && tilt_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/atau_pkg.sv
design/atau_angle_pipe.sv
design/accel_tilt_angles_unit.sv
bench/accel_tilt_angles_unit_tb.sv
